// ----- hw/rtl/sse_pkg.sv -----
// Shared types and constants for the segmented stack engine.
`timescale 1ns / 1ps

package sse_pkg;

  // Geometry of the element store
  localparam int unsigned MaxSubstacks  = 16;
  localparam int unsigned SubstackDepth = 8;
  localparam int unsigned DataWidth     = 32;
  localparam int unsigned StoreDepth    = MaxSubstacks * SubstackDepth;

  localparam int unsigned SubW  = $clog2(MaxSubstacks);
  localparam int unsigned CntW  = $clog2(MaxSubstacks + 1);
  localparam int unsigned PosW  = $clog2(SubstackDepth);
  localparam int unsigned FillW = $clog2(SubstackDepth + 1);
  localparam int unsigned AddrW = SubW + PosW;

  // Capacity register
  localparam int unsigned CapW = 4;
  localparam logic [CapW-1:0] CapReset = CapW'(2);

  // Field widths fixed by the interface
  localparam int unsigned CmdW    = 2;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_POP_AT = 2'd2,
    CMD_PEEK   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NOTHING  = 2'd2
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]             cmd;
    logic signed [DataWidth-1:0] push_value;
    logic [IndexW-1:0]           stack_index;
  } in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] top_value;
    logic                        top_valid;
    logic                        is_empty;
    logic [StatusW-1:0]          status;
  } out_t;

  // Per-request update from the control block to the datapath
  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             top_valid;
    logic             is_empty;
    status_e          status;
    logic             fwd;
  } upd_t;

endpackage

// ----- hw/rtl/sse_ram.sv -----
// Element store: one write port, one registered read port.
`timescale 1ns / 1ps

module sse_ram (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [sse_pkg::AddrW-1:0]        wr_addr_i,
  input  logic [sse_pkg::DataWidth-1:0]    wr_data_i,
  input  logic                             rd_en_i,
  input  logic [sse_pkg::AddrW-1:0]        rd_addr_i,
  output logic [sse_pkg::DataWidth-1:0]    rd_data_o
);
  import sse_pkg::*;

  logic [DataWidth-1:0] mem_q [StoreDepth];
  logic [DataWidth-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/sse_ctrl.sv -----
// Sub-stack bookkeeping: count, fill levels, capacity and per-request update.
`timescale 1ns / 1ps

module sse_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sse_pkg::CapW-1:0]    cfg_data_i,
  input  logic                        accept_i,
  input  logic [sse_pkg::CmdW-1:0]    cmd_i,
  input  logic [sse_pkg::IndexW-1:0]  stack_index_i,
  output sse_pkg::upd_t               upd_o
);
  import sse_pkg::*;

  logic [CapW-1:0]  cap_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [FillW-1:0] fill_q [MaxSubstacks];
  logic [FillW-1:0] fill_d [MaxSubstacks];

  logic [FillW-1:0] eff_cap;
  logic [SubW-1:0]  last;
  logic [CntW-1:0]  n_w;
  logic [SubW-1:0]  last_w;
  logic [SubW-1:0]  wr_sub;
  logic [PosW-1:0]  wr_pos;
  logic             wr_en;
  status_e          status;
  logic [SubW-1:0]  top_sub;
  logic [FillW-1:0] top_fill;
  logic             top_valid;

  // capacity clamped to 1..SubstackDepth
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = FillW'(1);
    end else if (cap_q > CapW'(SubstackDepth)) begin
      eff_cap = FillW'(SubstackDepth);
    end else begin
      eff_cap = FillW'(cap_q);
    end
  end

  assign last = SubW'(cnt_q - 1'b1);

  // command update
  always_comb begin
    fill_d = fill_q;
    cnt_d  = cnt_q;
    status = ST_DONE;
    wr_en  = 1'b0;
    wr_sub = '0;
    wr_pos = '0;
    n_w    = cnt_q;
    last_w = last;
    case (cmd_i)
      CMD_PUSH: begin
        if (cnt_q == '0) begin
          // no sub-stacks: open the first one
          cnt_d     = CntW'(1);
          fill_d[0] = FillW'(1);
          wr_en     = 1'b1;
        end else if (fill_q[last] >= eff_cap) begin
          if (cnt_q >= CntW'(MaxSubstacks)) begin
            status = ST_OVERFLOW;
          end else begin
            fill_d[SubW'(cnt_q)] = FillW'(1);
            cnt_d  = cnt_q + 1'b1;
            wr_en  = 1'b1;
            wr_sub = SubW'(cnt_q);
          end
        end else begin
          fill_d[last] = fill_q[last] + 1'b1;
          wr_en  = 1'b1;
          wr_sub = last;
          wr_pos = PosW'(fill_q[last]);
        end
      end
      CMD_POP: begin
        if (cnt_q == '0) begin
          status = ST_NOTHING;
        end else begin
          // drop an empty last sub-stack first
          if (fill_q[last] == '0) begin
            n_w = cnt_q - 1'b1;
          end
          last_w = SubW'(n_w - 1'b1);
          cnt_d  = n_w;
          if (n_w == '0 || fill_q[last_w] == '0) begin
            status = ST_NOTHING;
          end else begin
            fill_d[last_w] = fill_q[last_w] - 1'b1;
            if (fill_q[last_w] == FillW'(1)) begin
              cnt_d = n_w - 1'b1;
            end
          end
        end
      end
      CMD_POP_AT: begin
        if ({1'b0, stack_index_i} >= (IndexW + 1)'(cnt_q) ||
            fill_q[SubW'(stack_index_i)] == '0) begin
          status = ST_NOTHING;
        end else begin
          fill_d[SubW'(stack_index_i)] = fill_q[SubW'(stack_index_i)] - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // top of the last sub-stack after the update
  assign top_sub   = SubW'(cnt_d - 1'b1);
  assign top_fill  = fill_d[top_sub];
  assign top_valid = (cnt_d != '0) && (top_fill != '0);

  always_comb begin
    upd_o.wr_en     = wr_en;
    upd_o.wr_addr   = {wr_sub, wr_pos};
    upd_o.fwd       = wr_en;
    upd_o.top_valid = top_valid;
    upd_o.rd_en     = accept_i && top_valid && !wr_en;
    upd_o.rd_addr   = {top_sub, PosW'(top_fill - 1'b1)};
    upd_o.is_empty  = (cnt_d == '0) || (cnt_d == CntW'(1) && fill_d[0] == '0);
    upd_o.status    = status;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapReset;
      cnt_q  <= CntW'(1);
      fill_q <= '{default: '0};
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (accept_i) begin
        cnt_q  <= cnt_d;
        fill_q <= fill_d;
      end
    end
  end

endmodule

// ----- hw/rtl/segmented_stack_engine_core.sv -----
// Segmented stack engine: set of stacks with push, pop, pop_at and peek.
//
//  channel  | dir | valid/ready              | payload
//  ---------+-----+--------------------------+-------------------------
//  command  | in  | in_valid_i / in_ready_o  | in_data_i  (sse_pkg::in_t)
//  result   | out | out_valid_o / out_ready_i| out_data_o (sse_pkg::out_t)
//  capacity | in  | cfg_valid_i / cfg_ready_o| cfg_data_i (4 bits)
//
// One command per cycle while results are drained; its result is valid the cycle after the request is taken.
// That delay comes from the registered read port of the element store and the registered result flags.
// Reset: one empty sub-stack, capacity 2; the element store is not cleared.
// A stalled result holds in the output register; a new request is taken only
// when that register is empty or is being drained in the same cycle.
`timescale 1ns / 1ps

module segmented_stack_engine_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  sse_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output sse_pkg::out_t            out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [sse_pkg::CapW-1:0] cfg_data_i
);
  import sse_pkg::*;

  logic                 accept;
  upd_t                 upd;
  logic [DataWidth-1:0] rd_data;

  logic                 out_valid_q;
  logic                 top_valid_q;
  logic                 is_empty_q;
  logic [StatusW-1:0]   status_q;
  logic                 fwd_q;
  logic [DataWidth-1:0] pval_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  sse_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .cmd_i         (in_data_i.cmd),
    .stack_index_i (in_data_i.stack_index),
    .upd_o         (upd)
  );

  sse_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (accept && upd.wr_en),
    .wr_addr_i (upd.wr_addr),
    .wr_data_i (in_data_i.push_value),
    .rd_en_i   (upd.rd_en),
    .rd_addr_i (upd.rd_addr),
    .rd_data_o (rd_data)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_valid_q <= upd.top_valid;
      is_empty_q  <= upd.is_empty;
      status_q    <= upd.status;
      fwd_q       <= upd.fwd;
      pval_q      <= in_data_i.push_value;
    end
  end

  // a successful push is its own new top; otherwise take the store read, or zero when there is no valid top
  always_comb begin
    if (fwd_q) begin
      out_data_o.top_value = pval_q;
    end else if (top_valid_q) begin
      out_data_o.top_value = rd_data;
    end else begin
      out_data_o.top_value = '0;
    end
    out_data_o.top_valid = top_valid_q;
    out_data_o.is_empty  = is_empty_q;
    out_data_o.status    = status_q;
  end

  assign out_valid_o = out_valid_q;

endmodule
